>>> hdl/two_way_actuated_signal_control_assert.svh
`ifndef TWO_WAY_ACTUATED_SIGNAL_CONTROL_ASSERT_SVH
`define TWO_WAY_ACTUATED_SIGNAL_CONTROL_ASSERT_SVH

// same-cycle check
`define TASC_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tasc assertion failed");

// condition implies consequence in the next cycle
`define TASC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tasc assertion failed");

`endif

>>> hdl/tasc_pkg.sv
package tasc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned TRAVEL_W = 20;
    localparam int unsigned DUR_W    = 16;
    localparam int unsigned LIGHT_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GREEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBER       = 2'd2;

    localparam logic [TRAVEL_W-1:0] TRAVEL_RST    = 20'd5000;
    localparam logic [DUR_W-1:0]    MIN_GREEN_RST = 16'd10000;
    localparam logic [DUR_W-1:0]    AMBER_RST     = 16'd1000;

    typedef enum logic [LIGHT_W-1:0] {
        PH_RED       = 2'd0,
        PH_RED_AMBER = 2'd1,
        PH_GREEN     = 2'd2,
        PH_AMBER     = 2'd3
    } t_phase;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              car_left;
        logic              car_right;
    } t_item;

    typedef struct packed {
        logic [TRAVEL_W-1:0] travel_time_ms;
        logic [DUR_W-1:0]    min_green_ms;
        logic [DUR_W-1:0]    amber_ms;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic take;
    } t_hs;

endpackage

>>> hdl/tasc_if.sv
interface tasc_item_if import tasc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic              car_left;
    logic              car_right;

    modport source (output valid, now_ms, car_left, car_right, input ready);
    modport sink (input valid, now_ms, car_left, car_right, output ready);
endinterface

interface tasc_result_if import tasc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIGHT_W-1:0] left_light;
    logic [LIGHT_W-1:0] right_light;

    modport source (output valid, left_light, right_light, input ready);
    modport sink (input valid, left_light, right_light, output ready);
endinterface

interface tasc_cfg_if import tasc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/two_way_actuated_signal_control.sv
// Two-way vehicle-actuated signal controller.
// i_item carries a request: the current millisecond time and car-present
// flags for the left and right approaches. o_result returns one result per
// request: both light phases (0 red, 1 red+amber, 2 green, 3 amber) after
// the update. i_cfg writes travel time (index 0), minimum green (index 1)
// and amber time (index 2); it is always ready. The user must write it only
// while idle; the block itself does not enforce this. An accepted request
// lands in the input register, then passes the combinational phase update
// into the result register, which drives o_result. Throughput: one request
// per cycle while o_result takes each result.
// Reset: both sides red, the left side counts as having had the last green
// so the right side is served first, clearance deadline zero, phase
// deadline 10000 ms, registers back to 5000 / 10000 / 1000 ms.
// Stall: a result not taken holds in the result register; one more request
// waits in the input register, then i_item.ready drops until o_result
// drains.
module two_way_actuated_signal_control import tasc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tasc_item_if.sink     i_item,
    tasc_cfg_if.sink      i_cfg,
    tasc_result_if.source o_result
);

    t_cfg  cfg;
    t_hs   hs;
    t_item item;
    logic  take;

    tasc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tasc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (take),
        .o_hs    (hs),
        .o_item  (item)
    );

    tasc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_hs    (hs),
        .i_item  (item),
        .o_take  (take),
        .o_res   (o_result)
    );

endmodule

>>> hdl/tasc_cfg_regs.sv
module tasc_cfg_regs import tasc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tasc_cfg_if.sink       i_cfg,
    output t_cfg           o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.travel_time_ms <= TRAVEL_RST;
            r_cfg.min_green_ms   <= MIN_GREEN_RST;
            r_cfg.amber_ms       <= AMBER_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TRAVEL_TIME: r_cfg.travel_time_ms <= i_cfg.data[TRAVEL_W-1:0];
                CFG_MIN_GREEN:   r_cfg.min_green_ms   <= i_cfg.data[DUR_W-1:0];
                CFG_AMBER:       r_cfg.amber_ms       <= i_cfg.data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/tasc_in_stage.sv
module tasc_in_stage import tasc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tasc_item_if.sink i_item,
    input  logic      i_take,
    output t_hs       o_hs,
    output t_item     o_item
);

    logic  r_vld;
    t_item r_item;
    logic  accept;

    assign i_item.ready = !r_vld || i_take;
    assign accept       = i_item.valid && i_item.ready;
    assign o_hs.valid   = r_vld;
    assign o_hs.take    = i_take;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.now_ms    <= i_item.now_ms;
            r_item.car_left  <= i_item.car_left;
            r_item.car_right <= i_item.car_right;
        end
    end

endmodule

>>> hdl/tasc_core.sv
`include "two_way_actuated_signal_control_assert.svh"

module tasc_core import tasc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_hs           i_hs,
    input  t_item         i_item,
    output logic          o_take,
    tasc_result_if.source o_res
);

    t_phase            r_left, r_right, n_left, n_right;
    logic              r_last_left, n_last_left;
    logic [TIME_W-1:0] r_clr_dl, n_clr_dl;
    logic [TIME_W-1:0] r_ph_dl, n_ph_dl;
    logic              r_res_vld;
    t_phase            r_res_left, r_res_right;

    logic [TIME_W-1:0] amber_w, min_green_w, travel_w, amber_start, ra_end, now;
    logic              cl, cr, take;
    logic              l_red, l_ra, l_amb, l_grn, r_red, r_ra, r_amb, r_grn, extend;

    assign take   = i_hs.valid && (!r_res_vld || o_res.ready);
    assign o_take = take;

    assign now         = i_item.now_ms;
    assign cl          = i_item.car_left;
    assign cr          = i_item.car_right;
    assign amber_w     = {{(TIME_W-DUR_W){1'b0}}, i_cfg.amber_ms};
    assign min_green_w = {{(TIME_W-DUR_W){1'b0}}, i_cfg.min_green_ms};
    assign travel_w    = {{(TIME_W-TRAVEL_W){1'b0}}, i_cfg.travel_time_ms};
    assign amber_start = r_ph_dl - amber_w;
    assign ra_end      = r_clr_dl + amber_w;

    assign l_red = (r_left == PH_AMBER) && (now >= r_ph_dl);
    assign l_ra  = (r_left == PH_RED) && cl && (r_right == PH_RED) &&
                   (now >= r_clr_dl) && !r_last_left;
    assign l_amb = (r_left == PH_GREEN) && cr && (now >= amber_start);
    assign l_grn = (r_left == PH_RED_AMBER) && (now >= ra_end);

    assign r_red = (r_right == PH_AMBER) && (now >= r_ph_dl);
    assign r_ra  = (r_right == PH_RED) && cr && (r_left == PH_RED) &&
                   (now >= r_clr_dl) && r_last_left;
    assign r_amb = (r_right == PH_GREEN) && cl && (now >= amber_start);
    assign r_grn = (r_right == PH_RED_AMBER) && (now >= ra_end);

    assign extend = (cl && (r_left == PH_GREEN || r_left == PH_AMBER)) ||
                    (cr && (r_right == PH_GREEN || r_right == PH_AMBER));

    // later conditions override earlier ones
    always_comb begin
        n_left      = r_left;
        n_right     = r_right;
        n_last_left = r_last_left;
        n_clr_dl    = r_clr_dl;
        n_ph_dl     = r_ph_dl;
        if (extend) begin
            n_clr_dl = now + travel_w;
        end
        if (l_red) begin
            n_left = PH_RED;
        end
        if (l_ra) begin
            n_left      = PH_RED_AMBER;
            n_last_left = 1'b1;
            n_clr_dl    = now;
            n_ph_dl     = now + min_green_w;
        end
        if (l_amb) begin
            n_left  = PH_AMBER;
            n_ph_dl = now + amber_w;
        end
        if (l_grn) begin
            n_left = PH_GREEN;
        end
        if (r_red) begin
            n_right = PH_RED;
        end
        if (r_ra) begin
            n_right     = PH_RED_AMBER;
            n_last_left = 1'b0;
            n_clr_dl    = now;
            n_ph_dl     = now + min_green_w;
        end
        if (r_amb) begin
            n_right = PH_AMBER;
            n_ph_dl = now + amber_w;
        end
        if (r_grn) begin
            n_right = PH_GREEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= PH_RED;
            r_right     <= PH_RED;
            r_last_left <= 1'b1;
            r_clr_dl    <= '0;
            r_ph_dl     <= {{(TIME_W-DUR_W){1'b0}}, MIN_GREEN_RST};
            r_res_vld   <= 1'b0;
        end else begin
            if (take) begin
                r_left      <= n_left;
                r_right     <= n_right;
                r_last_left <= n_last_left;
                r_clr_dl    <= n_clr_dl;
                r_ph_dl     <= n_ph_dl;
                r_res_vld   <= 1'b1;
            end else if (o_res.ready) begin
                r_res_vld   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res_left  <= n_left;
            r_res_right <= n_right;
        end
    end

    assign o_res.valid       = r_res_vld;
    assign o_res.left_light  = r_res_left;
    assign o_res.right_light = r_res_right;

    `TASC_ASSERT_NOW(a_one_side_open, i_clk, i_rst_n, (r_left == PH_RED) || (r_right == PH_RED))
    `TASC_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, !(r_res_vld && !o_res.ready) || !take)
    `TASC_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n, take, r_res_vld)
    `TASC_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !take, $stable(r_left) && $stable(r_right))

endmodule
